### rtl/core/wodr_pkg.sv
`default_nettype none
package wodr_pkg;

    localparam int PathPoints  = 1024;
    localparam int CordicSteps = 18;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] CFG_PPU   = 2'd0;
    localparam logic [1:0] CFG_LREV  = 2'd1;
    localparam logic [1:0] CFG_RREV  = 2'd2;

    localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDIV,
        ST_RDIV,
        ST_SUM,
        ST_ROT,
        ST_MULX,
        ST_MULY,
        ST_ACC,
        ST_OUT
    } state_t;

    // control from sequencer to divider
    typedef struct packed {
        logic        start;
        logic [17:0] dividend;
        logic [15:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic        busy;
        logic [17:0] quotient;
        logic [16:0] remainder;
    } div_sts_t;

    function automatic logic signed [23:0] atan_entry(input logic [4:0] i);
        logic signed [23:0] r;
        begin
            case (i)
                5'd0:  r = 24'sd2949120;
                5'd1:  r = 24'sd1740967;
                5'd2:  r = 24'sd919879;
                5'd3:  r = 24'sd466945;
                5'd4:  r = 24'sd234379;
                5'd5:  r = 24'sd117304;
                5'd6:  r = 24'sd58666;
                5'd7:  r = 24'sd29335;
                5'd8:  r = 24'sd14668;
                5'd9:  r = 24'sd7334;
                5'd10: r = 24'sd3667;
                5'd11: r = 24'sd1833;
                5'd12: r = 24'sd917;
                5'd13: r = 24'sd458;
                5'd14: r = 24'sd229;
                5'd15: r = 24'sd115;
                5'd16: r = 24'sd57;
                5'd17: r = 24'sd29;
                default: r = 24'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/wheel_odometry_dead_reckoning.sv
`default_nettype none
// A recorded sample raises m_tvalid after its request is taken and these steps run in order:
// two divisions (start, 17 quotient bits, completion), a sum step, 18 CORDIC rotations,
// two multiplies, the accumulate and the output step.
// Commands and ignored samples go straight to the output step, which raises m_tvalid.
// One request at a time: no new request is taken until the block is back in idle.
// Reset (rst_n, asynchronous, active low) clears the control and accumulator state and loads register defaults.
module wheel_odometry_dead_reckoning
    import wodr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: left_delta[15:0], right_delta[31:16], heading[47:32]
    input  wire logic [47:0] s_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: pos_x[47:0], pos_y[95:48], point_heading[111:96], point_number[122:112]
    output logic [127:0]     m_tdata,
    // tuser: accepted
    output logic             m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    state_t state_reg, state_next;

    logic [15:0] ppu_reg;
    logic        lrev_reg, rrev_reg;
    logic signed [47:0] ltot_reg, ltot_next, rtot_reg, rtot_next;
    logic signed [16:0] lres_reg, lres_next, rres_reg, rres_next;
    logic signed [48:0] prev_reg, prev_next;
    logic signed [47:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        rec_reg, rec_next;

    // held request
    logic signed [15:0] lp_reg, lp_next, rp_reg, rp_next, hd_reg, hd_next;

    // CORDIC and product working registers
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [25:0] cz_reg, cz_next;
    logic        cneg_reg, cneg_next;
    logic [4:0]  step_reg, step_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [66:0] prod_reg, prod_next;
    logic signed [47:0] incx_reg, incx_next;

    // output register
    logic        ov_reg, ov_next;
    logic        oacc_reg, oacc_next;
    logic [15:0] oph_reg, oph_next;

    div_ctl_t dctl;
    div_sts_t dsts;
    logic     dbusy_reg;

    wodr_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (dctl),
        .sts  (dsts)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ppu_reg   <= 16'd1024;
            lrev_reg  <= 1'b0;
            rrev_reg  <= 1'b1;
            ltot_reg  <= '0;
            rtot_reg  <= '0;
            lres_reg  <= '0;
            rres_reg  <= '0;
            prev_reg  <= '0;
            accx_reg  <= '0;
            accy_reg  <= '0;
            cnt_reg   <= '0;
            rec_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            dbusy_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ltot_reg  <= ltot_next;
            rtot_reg  <= rtot_next;
            lres_reg  <= lres_next;
            rres_reg  <= rres_next;
            prev_reg  <= prev_next;
            accx_reg  <= accx_next;
            accy_reg  <= accy_next;
            cnt_reg   <= cnt_next;
            rec_reg   <= rec_next;
            ov_reg    <= ov_next;
            dbusy_reg <= dsts.busy;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_PPU:  ppu_reg  <= cfg_wdata;
                    CFG_LREV: lrev_reg <= cfg_wdata[0];
                    CFG_RREV: rrev_reg <= cfg_wdata[0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk) begin
        lp_reg   <= lp_next;
        rp_reg   <= rp_next;
        hd_reg   <= hd_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        cneg_reg <= cneg_next;
        step_reg <= step_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        incx_reg <= incx_next;
        oacc_reg <= oacc_next;
        oph_reg  <= oph_next;
    end

    logic signed [17:0] lsigned, rsigned;
    logic signed [48:0] sum_w;
    logic signed [49:0] dif_w;
    logic signed [15:0] hred;
    logic signed [33:0] xs, ys;
    logic signed [23:0] at;
    logic signed [33:0] mul_b;
    logic signed [47:0] rnd;
    logic div_done;

    assign div_done = dbusy_reg && !dsts.busy;

    always_comb begin
        state_next = state_reg;
        ltot_next = ltot_reg; rtot_next = rtot_reg;
        lres_next = lres_reg; rres_next = rres_reg;
        prev_next = prev_reg;
        accx_next = accx_reg; accy_next = accy_reg;
        cnt_next  = cnt_reg;  rec_next  = rec_reg;
        lp_next = lp_reg; rp_next = rp_reg; hd_next = hd_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        cneg_next = cneg_reg; step_next = step_reg;
        d_next = d_reg; prod_next = prod_reg; incx_next = incx_reg;
        ov_next = ov_reg; oacc_next = oacc_reg; oph_next = oph_reg;
        dctl = '0;
        dctl.divisor = ppu_reg;
        s_tready = 1'b0;

        // sign-adjusted dividends; residue plus a negated extreme needs 18 bits
        lsigned = 18'(lres_reg) + (lrev_reg ? -18'(lp_reg) : 18'(lp_reg));
        rsigned = 18'(rres_reg) + (rrev_reg ? -18'(rp_reg) : 18'(rp_reg));
        sum_w   = 49'(ltot_reg) + 49'(rtot_reg);
        dif_w   = 50'(sum_w) - 50'(prev_reg);
        hred    = hd_reg;
        xs      = cx_reg >>> step_reg;
        ys      = cy_reg >>> step_reg;
        at      = atan_entry(step_reg);
        mul_b   = (state_reg == ST_MULX) ? (cneg_reg ? -cx_reg : cx_reg)
                                         : (cneg_reg ? -cy_reg : cy_reg);
        rnd     = 48'((prod_reg + 67'sd16384) >>> 15);

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = !ov_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    lp_next = s_tdata[15:0];
                    rp_next = s_tdata[31:16];
                    hd_next = s_tdata[47:32];
                    oacc_next = 1'b0;
                    oph_next  = '0;
                    state_next = ST_OUT;
                    unique case (s_tuser)
                        ACT_START: rec_next = 1'b1;
                        ACT_STOP:  rec_next = 1'b0;
                        ACT_CLEAR: begin
                            rec_next = 1'b0;
                            cnt_next = '0;
                        end
                        ACT_SAMPLE: begin
                            if (rec_reg && cnt_reg < 11'(PathPoints)) begin
                                state_next = ST_LDIV;
                                step_next  = 5'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LDIV: begin
                // step 0 starts the division; wait for its completion
                if (step_reg == 5'd0) begin
                    dctl.start = 1'b1;
                    dctl.dividend = lsigned;
                    step_next = 5'd1;
                end else if (div_done) begin
                    ltot_next = ltot_reg + 48'(signed'(dsts.quotient));
                    lres_next = dsts.remainder;
                    step_next = 5'd0;
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                if (step_reg == 5'd0) begin
                    dctl.start = 1'b1;
                    dctl.dividend = rsigned;
                    step_next = 5'd1;
                end else if (div_done) begin
                    rtot_next = rtot_reg + 48'(signed'(dsts.quotient));
                    rres_next = dsts.remainder;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (dif_w > 50'sd4294967295) begin
                    d_next = 33'sd4294967295;
                end else if (dif_w < -50'sd4294967295) begin
                    d_next = -33'sd4294967295;
                end else begin
                    d_next = 33'(dif_w);
                end
                prev_next = sum_w;
                cneg_next = 1'b0;
                if (hred > 16'sd11520) begin
                    hred = hred - 16'sd23040;
                    cneg_next = 1'b1;
                end else if (hred < -16'sd11520) begin
                    hred = hred + 16'sd23040;
                    cneg_next = 1'b1;
                end
                cz_next = 26'(hred) <<< 9;
                cx_next = CordicGain;
                cy_next = '0;
                step_next = 5'd0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                if (!cz_reg[25]) begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - 26'(at);
                end else begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + 26'(at);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(CordicSteps - 1)) begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                prod_next  = 67'(d_reg) * 67'(mul_b);
                state_next = ST_MULY;
            end
            ST_MULY: begin
                incx_next  = rnd;
                prod_next  = 67'(d_reg) * 67'(mul_b);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                accx_next = accx_reg + incx_reg;
                accy_next = accy_reg + rnd;
                cnt_next  = cnt_reg + 11'd1;
                oacc_next = 1'b1;
                oph_next  = hd_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = oacc_reg;
    assign m_tdata  = {5'd0, cnt_reg, oph_reg, accy_reg, accx_reg};

    // hold the result stable while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_tready |=> ov_reg && $stable(m_tdata))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("ready while busy");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 11'(PathPoints))
        else $error("point count past limit");

endmodule
`default_nettype wire

### rtl/core/wodr_divider.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle, truncating toward zero.
module wodr_divider
    import wodr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_ctl_t ctl,
    output div_sts_t      sts
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [17:0] trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[16]} - {2'b00, dvs_reg};
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd17;
            neg_next  = ctl.dividend[17];
            quo_next  = ctl.dividend[17] ? 17'(-ctl.dividend) : ctl.dividend[16:0];
            rem_next  = '0;
            dvs_next  = (ctl.divisor == 16'd0) ? 16'd1 : ctl.divisor;
        end else if (busy_reg) begin
            if (!trial[17]) begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[15:0], 1'b1};
            end else begin
                rem_next = {rem_reg[15:0], quo_reg[16]};
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    assign sts.busy      = busy_reg;
    assign sts.quotient  = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
    assign sts.remainder = neg_reg ? 17'(-rem_reg) : rem_reg;

endmodule
`default_nettype wire
